// ----- src/c32mh_pkg.sv -----
// ----------------------------------------------------------------------------
// c32mh_pkg: shared constants, types and functions for the CRC32C multiply hash
// Holds the CRC32C column tables, the mixing constants and the stage item type.
// ----------------------------------------------------------------------------
package c32mh_pkg;

    localparam logic [31:0] CRC_POLY    = 32'h82F6_3B78;
    localparam logic [31:0] SECOND_SEED = 32'h04C1_1DB7;
    localparam logic [63:0] MIX_MULT    = 64'h2545_F491_4F6C_DD1D;
    localparam logic [31:0] MIX_MULT_LO = MIX_MULT[31:0];
    localparam logic [31:0] MIX_MULT_HI = MIX_MULT[63:32];

    localparam logic [3:0] FULL_BYTES = 4'd8;
    localparam logic [3:0] HALF_BYTES = 4'd4;

    typedef logic [63:0][31:0] data_cols_t;
    typedef logic [31:0][31:0] seed_cols_t;

    // Bit-serial CRC32C, used only on constants to build the tables below
    function automatic logic [31:0] crc32c_serial(logic [31:0] seed, logic [63:0] data);
        logic [31:0] crc;
        logic        fb;
        crc = seed;
        for (int i = 0; i < 64; i++) begin
            fb  = crc[0] ^ data[i];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic data_cols_t make_data_cols();
        data_cols_t cols;
        for (int i = 0; i < 64; i++) begin
            cols[i] = crc32c_serial(32'd0, 64'd1 << i);
        end
        return cols;
    endfunction

    function automatic seed_cols_t make_seed_cols();
        seed_cols_t cols;
        for (int k = 0; k < 32; k++) begin
            cols[k] = crc32c_serial(32'd1 << k, 64'd0);
        end
        return cols;
    endfunction

    localparam data_cols_t  DATA_COLS     = make_data_cols();
    localparam seed_cols_t  SEED_COLS     = make_seed_cols();
    localparam logic [31:0] SECOND_SEED_CRC = crc32c_serial(SECOND_SEED, 64'd0);

    // The CRC is linear: fold each set input bit's column into the result
    function automatic logic [31:0] crc_of_data(logic [63:0] data);
        logic [31:0] acc;
        acc = '0;
        for (int i = 0; i < 64; i++) begin
            if (data[i]) begin
                acc = acc ^ DATA_COLS[i];
            end
        end
        return acc;
    endfunction

    function automatic logic [31:0] crc_of_seed(logic [31:0] seed);
        logic [31:0] acc;
        acc = '0;
        for (int k = 0; k < 32; k++) begin
            if (seed[k]) begin
                acc = acc ^ SEED_COLS[k];
            end
        end
        return acc;
    endfunction

    // Item handed from the mix stage to the finish stage
    typedef struct packed {
        logic [31:0] crc_lo;     // first CRC, low half of the mixed word
        logic [63:0] lo_prod;    // crc_lo times low multiplier half, full width
        logic [31:0] hi_prod;    // second CRC times low multiplier half, low bits
        logic [23:0] tail;       // masked tail bytes to xor into the hash
        logic        mix;
        logic        last;
    } mix_item_t;

endpackage

// ----- src/c32mh_mix.sv -----
// ----------------------------------------------------------------------------
// c32mh_mix: input register and CRC/multiply stage
// Registers each item, computes both CRCs and the partial products, and keeps
// the low half of the running hash, which is all the feedback loop needs.
// ----------------------------------------------------------------------------
module c32mh_mix (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [63:0]          s_data_word,
    input  logic [3:0]           s_byte_count,
    input  logic                 s_last_word,
    output logic                 mix_valid,
    input  logic                 mix_ready,
    output c32mh_pkg::mix_item_t mix_item
);

    logic        in_valid_reg;
    logic [63:0] in_data_reg;
    logic [3:0]  in_count_reg;
    logic        in_last_reg;

    logic                 mx_valid_reg;
    c32mh_pkg::mix_item_t mx_item_reg;
    c32mh_pkg::mix_item_t mx_item_next;
    logic [31:0]          hash_lo_reg;
    logic [31:0]          hash_lo_next;

    logic        mx_ready;
    logic        in_ready;
    logic [3:0]  count_sat;
    logic        full_word;
    logic        chunk;
    logic [63:0] word;
    logic [31:0] data_crc;
    logic [31:0] crc_a;
    logic [31:0] crc_b;
    logic [63:0] lo_prod;
    logic [1:0]  tail_len;
    logic [23:0] tail_src;
    logic [23:0] tail_mask;

    assign mx_ready = !mx_valid_reg || mix_ready;
    assign in_ready = !in_valid_reg || mx_ready;
    assign s_ready  = in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && in_ready) begin
            in_data_reg  <= s_data_word;
            in_count_reg <= s_byte_count;
            in_last_reg  <= s_last_word;
        end
    end

    // Counts above eight behave as eight
    assign count_sat = (in_count_reg > c32mh_pkg::FULL_BYTES) ? c32mh_pkg::FULL_BYTES
                                                              : in_count_reg;
    assign full_word = !in_last_reg || (count_sat == c32mh_pkg::FULL_BYTES);
    assign chunk     = in_last_reg && (count_sat >= c32mh_pkg::HALF_BYTES)
                       && (count_sat < c32mh_pkg::FULL_BYTES);
    assign word      = chunk ? {32'd0, in_data_reg[31:0]} : in_data_reg;

    assign data_crc = c32mh_pkg::crc_of_data(word);
    assign crc_a    = c32mh_pkg::crc_of_seed(hash_lo_reg) ^ data_crc;
    assign crc_b    = c32mh_pkg::SECOND_SEED_CRC ^ data_crc;
    assign lo_prod  = 64'(crc_a) * 64'(c32mh_pkg::MIX_MULT_LO);

    // Tail length is the count modulo four on a partial last word
    assign tail_len = full_word ? 2'd0 : count_sat[1:0];
    assign tail_src = chunk ? in_data_reg[55:32] : in_data_reg[23:0];

    always_comb begin
        case (tail_len)
            2'd0:    tail_mask = 24'h00_0000;
            2'd1:    tail_mask = 24'h00_00FF;
            2'd2:    tail_mask = 24'h00_FFFF;
            2'd3:    tail_mask = 24'hFF_FFFF;
            default: tail_mask = 24'h00_0000;
        endcase
    end

    always_comb begin
        mx_item_next.crc_lo  = crc_a;
        mx_item_next.lo_prod = lo_prod;
        mx_item_next.hi_prod = 32'(crc_b * c32mh_pkg::MIX_MULT_LO);
        mx_item_next.tail    = tail_src & tail_mask;
        mx_item_next.mix     = full_word || chunk;
        mx_item_next.last    = in_last_reg;
        // Drop the running hash after a last item; the next key starts from zero
        hash_lo_next = in_last_reg ? 32'd0 : lo_prod[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mx_valid_reg <= 1'b0;
            hash_lo_reg  <= 32'd0;
        end else begin
            if (mx_ready) begin
                mx_valid_reg <= in_valid_reg;
            end
            if (in_valid_reg && mx_ready) begin
                hash_lo_reg <= hash_lo_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && mx_ready) begin
            mx_item_reg <= mx_item_next;
        end
    end

    assign mix_valid = mx_valid_reg;
    assign mix_item  = mx_item_reg;

    a_lo_cleared_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && mx_ready && in_last_reg) |=> (hash_lo_reg == 32'd0))
        else $error("running hash low half not cleared after last item");

    a_lo_follows_product: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && mx_ready && !in_last_reg)
        |=> (hash_lo_reg == mx_item_reg.lo_prod[31:0]))
        else $error("running hash low half differs from registered product");

    a_non_last_mixes: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && mx_ready && !in_last_reg)
        |=> (mx_item_reg.mix && (mx_item_reg.tail == 24'd0)))
        else $error("non-last item not mixed as a full word");

endmodule

// ----- src/c32mh_finish.sv -----
// ----------------------------------------------------------------------------
// c32mh_finish: product assembly, full running hash and result register
// Completes the 64-bit product, applies tail bytes and holds the result item.
// ----------------------------------------------------------------------------
module c32mh_finish (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 mix_valid,
    output logic                 mix_ready,
    input  c32mh_pkg::mix_item_t mix_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [63:0]          m_hash_value
);

    logic [63:0] hash_reg;
    logic [63:0] hash_next;
    logic        out_valid_reg;
    logic [63:0] out_hash_reg;

    logic        out_free;
    logic        fire;
    logic [31:0] upper_sum;
    logic [63:0] product;
    logic [63:0] mixed;
    logic [63:0] result;

    assign out_free  = !out_valid_reg || m_ready;
    // Non-last items never touch the result register
    assign mix_ready = !mix_item.last || out_free;
    assign fire      = mix_valid && mix_ready;

    assign upper_sum = 32'(mix_item.crc_lo * c32mh_pkg::MIX_MULT_HI) + mix_item.hi_prod;
    assign product   = mix_item.lo_prod + {upper_sum, 32'd0};
    assign mixed     = mix_item.mix ? product : hash_reg;
    assign result    = mixed ^ {40'd0, mix_item.tail};
    assign hash_next = mix_item.last ? 64'd0 : mixed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg      <= 64'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                hash_reg <= hash_next;
            end
            out_valid_reg <= (out_valid_reg && !m_ready) || (fire && mix_item.last);
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && mix_item.last) begin
            out_hash_reg <= result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_hash_value = out_hash_reg;

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && mix_item.last) |=> out_valid_reg)
        else $error("last item did not produce a result");

    a_non_last_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !mix_item.last && !out_valid_reg) |=> !out_valid_reg)
        else $error("non-last item produced a result");

    a_hash_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && mix_item.last) |=> (hash_reg == 64'd0))
        else $error("running hash not cleared after result");

endmodule

// ----- src/crc32c_multiply_hash64.sv -----
// A last item goes from the input register to the mix register, then to the result register.
// Throughput: one item per cycle unless stalled; loop is low-half CRC plus a 32x32 multiply.
// A stalled result side holds a last item at the finish stage, which then holds every
// item behind it; non-last items ahead of it pass on without waiting.
// Reset (aresetn low, synchronous) empties all stages and sets the running hash to zero.
// ----------------------------------------------------------------------------
// crc32c_multiply_hash64: CRC32C multiply hash over 64-bit key words
// Mixes each word into a 64-bit running hash and returns it on the last word.
// ----------------------------------------------------------------------------
module crc32c_multiply_hash64 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_word,
    input  logic [3:0]  s_byte_count,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_value
);

    logic                 mix_valid;
    logic                 mix_ready;
    c32mh_pkg::mix_item_t mix_item;

    c32mh_mix u_mix (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_word  (s_data_word),
        .s_byte_count (s_byte_count),
        .s_last_word  (s_last_word),
        .mix_valid    (mix_valid),
        .mix_ready    (mix_ready),
        .mix_item     (mix_item)
    );

    c32mh_finish u_finish (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .mix_valid    (mix_valid),
        .mix_ready    (mix_ready),
        .mix_item     (mix_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

endmodule

// ----- dv/tb_crc32c_multiply_hash64.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crc32c_multiply_hash64: self-checking bench for the CRC32C multiply hash
// Feeds keys as streams of 64-bit words, directed rows first and random keys
// after, with bursty input and a stalling result side. A local model of the
// hash, or the row's typed value, predicts each key's result, checked in order on the output.
// ----------------------------------------------------------------------------
module tb_crc32c_multiply_hash64;

    localparam logic [31:0] CRC32C_POLY  = 32'h82F6_3B78;
    localparam logic [31:0] HI_SEED      = 32'h04C1_1DB7;
    localparam logic [63:0] MULTIPLIER   = 64'h2545_F491_4F6C_DD1D;
    localparam logic [3:0]  WORD_BYTES   = 4'd8;
    localparam logic [3:0]  CHUNK_BYTES  = 4'd4;
    localparam int          RANDOM_ITEMS = 1625;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [63:0] ONES         = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
        logic        typed;   // hash below is the expected result
        logic [63:0] hash;
    } stim_row_t;

    localparam int NUM_ROWS = 23;
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // empty key and tail-only keys: the hash is just the tail bytes
        '{ONES,                   4'd0,  1'b1, 1'b1, 64'h0},
        '{ONES,                   4'd1,  1'b1, 1'b1, 64'hFF},
        '{64'hDEAD_BEEF_CAFE_1234, 4'd2,  1'b1, 1'b1, 64'h1234},
        '{64'hFFFF_FFFF_FFAB_CDEF, 4'd3,  1'b1, 1'b1, 64'hAB_CDEF},
        '{64'h0,                  4'd0,  1'b1, 1'b1, 64'h0},
        // partial words: 4-byte chunk plus tail
        '{ONES,                   4'd4,  1'b1, 1'b0, 64'h0},
        '{64'h0123_4567_89AB_CDEF, 4'd5,  1'b1, 1'b0, 64'h0},
        '{64'hFEDC_BA98_7654_3210, 4'd6,  1'b1, 1'b0, 64'h0},
        '{ONES,                   4'd7,  1'b1, 1'b0, 64'h0},
        // full last words, count above eight acts as eight
        '{64'h0,                  4'd8,  1'b1, 1'b0, 64'h0},
        '{ONES,                   4'd8,  1'b1, 1'b0, 64'h0},
        '{64'h8000_0000_0000_0001, 4'd9,  1'b1, 1'b0, 64'h0},
        '{64'h5A5A_A5A5_0F0F_F0F0, 4'd15, 1'b1, 1'b0, 64'h0},
        // multi-word keys, count ignored on the leading words
        '{ONES,                   4'd0,  1'b0, 1'b0, 64'h0},
        '{64'h0,                  4'd15, 1'b0, 1'b0, 64'h0},
        '{64'h1122_3344_5566_7788, 4'd3,  1'b1, 1'b0, 64'h0},
        '{64'h8000_0000_0000_0001, 4'd8,  1'b0, 1'b0, 64'h0},
        '{64'h0BAD_F00D_1234_5678, 4'd4,  1'b0, 1'b0, 64'h0},
        '{ONES,                   4'd7,  1'b1, 1'b0, 64'h0},
        '{64'hA5A5_A5A5_A5A5_A5A5, 4'd2,  1'b0, 1'b0, 64'h0},
        '{64'h7FFF_FFFF_FFFF_FFFE, 4'd0,  1'b1, 1'b0, 64'h0},
        '{64'hC3C3_3C3C_9999_6666, 4'd1,  1'b0, 1'b0, 64'h0},
        '{64'h0000_0000_8000_0000, 4'd15, 1'b1, 1'b0, 64'h0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_data_word = '0;
    logic [3:0]  s_byte_count = '0;
    logic        s_last_word = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_hash_value;

    logic [63:0] key_hash = '0;          // running hash of the key being fed
    logic [63:0] hash_queue [$];         // key hashes still to come out
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          items_sent = 0;

    crc32c_multiply_hash64 i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_word  (s_data_word),
        .s_byte_count (s_byte_count),
        .s_last_word  (s_last_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    always #10 aclk = ~aclk;

    // Reflected CRC32C over 64 data bits, LSB first, no inversion
    function automatic logic [31:0] crc32c_fold(logic [31:0] seed, logic [63:0] d);
        logic [31:0] crc;
        crc = seed;
        for (int i = 0; i < 64; i++) begin
            crc = (crc >> 1) ^ (CRC32C_POLY & {32{crc[0] ^ d[i]}});
        end
        return crc;
    endfunction

    function automatic logic [63:0] mix_word(logic [63:0] d, logic [63:0] h);
        return {crc32c_fold(HI_SEED, d), crc32c_fold(h[31:0], d)} * MULTIPLIER;
    endfunction

    // Advance the running hash by one item; done marks a finished key
    function automatic void fold_item(input logic [63:0] d, input logic [3:0] c,
                                      input logic last, output bit done,
                                      output logic [63:0] h);
        logic [3:0]  n;
        int          off;
        logic [63:0] acc;
        done = last;
        h    = '0;
        if (!last) begin
            key_hash = mix_word(d, key_hash);
        end else begin
            n   = (c > WORD_BYTES) ? WORD_BYTES : c;
            acc = key_hash;
            off = 0;
            if (n == WORD_BYTES) begin
                acc = mix_word(d, acc);
                n   = 4'd0;
            end else if (n >= CHUNK_BYTES) begin
                acc = mix_word({32'h0, d[31:0]}, acc);
                off = 4;
                n   = n - CHUNK_BYTES;
            end
            for (int i = 0; i < n; i++) begin
                acc[8*i +: 8] = acc[8*i +: 8] ^ d[8*(off+i) +: 8];
            end
            h        = acc;
            key_hash = '0;
        end
    endfunction

    task automatic send_item(input logic [63:0] d, input logic [3:0] c, input logic last,
                             input logic typed, input logic [63:0] typed_hash);
        bit          done;
        logic [63:0] h;
        s_valid      <= 1'b1;
        s_data_word  <= d;
        s_byte_count <= c;
        s_last_word  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        fold_item(d, c, last, done, h);
        if (done) begin
            hash_queue.push_back(typed ? typed_hash : h);
        end
        items_sent++;
        // end a burst with a random gap, then pick the next burst length
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(0, 15);
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic [63:0] random_data();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [3:0] random_last_count();
        case ($urandom_range(0, 9))
            0, 1:    return WORD_BYTES;
            2:       return 4'($urandom_range(9, 15));
            default: return 4'($urandom_range(0, 7));
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] expected,
                                 input logic [63:0] actual);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected %h, got %h", $realtime, what, expected, actual);
        end
    endtask

    initial begin
        int words;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_ROWS[r]) begin
            send_item(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].count, DIRECTED_ROWS[r].last,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].hash);
        end

        // random keys of up to twenty leading words and one last word
        while (items_sent < NUM_ROWS + RANDOM_ITEMS) begin
            words = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
            repeat (words) begin
                send_item(random_data(), 4'($urandom_range(0, 15)), 1'b0, 1'b0, '0);
            end
            send_item(random_data(), random_last_count(), 1'b1, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (hash_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Result side: switch at random between four ready patterns
    int ready_mode = 0;
    int mode_left = 0;
    int pattern_phase = 0;
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(64, 512);
        end else begin
            mode_left--;
        end
        pattern_phase++;
        case (ready_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 1) == 1);
            2:       m_ready <= (pattern_phase % 8 == 0);
            default: m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (hash_queue.size() == 0) begin
                note_mismatch("unexpected result", '0, m_hash_value);
            end else if (m_hash_value !== hash_queue[0]) begin
                note_mismatch("hash_value", hash_queue[0], m_hash_value);
                void'(hash_queue.pop_front());
            end else begin
                void'(hash_queue.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
